FILE: design/cgp_pkg.sv
package cgp_pkg;

  localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE = 8'h39;  // '9'
  localparam logic [7:0] CH_A    = 8'h41;  // 'A'
  localparam logic [7:0] CH_Z    = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_D    = 8'h44;  // 'D'
  localparam logic [7:0] CH_H    = 8'h48;  // 'H'
  localparam logic [7:0] CH_S    = 8'h53;  // 'S'

  localparam int OUT_LEN_W  = 32;
  localparam int OUT_DATA_W = 136;

  // character class of one beat
  typedef struct packed {
    logic       is_digit;
    logic       is_letter;
    logic       is_del;
    logic       is_clip;
    logic [3:0] digit;
  } char_class_t;

  // one finished string
  typedef struct packed {
    logic                 parse_error;
    logic [OUT_LEN_W-1:0] last_op_length;
    logic [OUT_LEN_W-1:0] first_op_length;
    logic                 back_clipped;
    logic                 front_clipped;
    logic [OUT_LEN_W-1:0] aligned_length;
    logic [OUT_LEN_W-1:0] read_length;
  } result_t;

endpackage

FILE: design/cgp_decode.sv
module cgp_decode
  import cgp_pkg::*;
(
  input  logic [7:0]  char_code,
  output char_class_t cls
);

  always_comb begin
    cls.is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    cls.is_letter = (char_code >= CH_A) && (char_code <= CH_Z);
    cls.is_del    = (char_code == CH_D);
    cls.is_clip   = (char_code == CH_S) || (char_code == CH_H);
    cls.digit     = 4'(char_code - CH_ZERO);
  end

endmodule

FILE: design/cgp_core.sv
module cgp_core
  import cgp_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  char_class_t cls,
  input  logic        eos,
  output result_t     res
);

  localparam int L = LENGTH_BITS;

  logic [L-1:0] acc_r, acc_nxt;
  logic [L-1:0] rd_sum_r, rd_sum_nxt;
  logic [L-1:0] al_sum_r, al_sum_nxt;
  logic         have_first_r, have_first_nxt;
  logic         first_clip_r, first_clip_nxt;
  logic [L-1:0] first_len_r, first_len_nxt;
  logic         recent_clip_r, recent_clip_nxt;
  logic [L-1:0] recent_len_r, recent_len_nxt;
  logic         err_r, err_nxt;

  function automatic logic [L-1:0] sat_add(input logic [L-1:0] a, input logic [L-1:0] b);
    logic [L:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[L] ? {L{1'b1}} : s[L-1:0];
  endfunction

  // clamp an L-bit length onto the 32-bit result field
  function automatic logic [OUT_LEN_W-1:0] clamp(input logic [L-1:0] v);
    logic [L+OUT_LEN_W-1:0] ext;
    ext = {{OUT_LEN_W{1'b0}}, v};
    return (ext[L+OUT_LEN_W-1:OUT_LEN_W] != '0) ? {OUT_LEN_W{1'b1}}
                                                 : ext[OUT_LEN_W-1:0];
  endfunction

  // acc*10 + d as shifts and adds, saturating
  logic [L+3:0] dec_wide;
  logic [L-1:0] dec_sat;
  always_comb begin
    dec_wide = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + (L+4)'(cls.digit);
    dec_sat  = (dec_wide[L+3:L] != 4'b0) ? {L{1'b1}} : dec_wide[L-1:0];
  end

  always_comb begin
    acc_nxt         = acc_r;
    rd_sum_nxt      = rd_sum_r;
    al_sum_nxt      = al_sum_r;
    have_first_nxt  = have_first_r;
    first_clip_nxt  = first_clip_r;
    first_len_nxt   = first_len_r;
    recent_clip_nxt = recent_clip_r;
    recent_len_nxt  = recent_len_r;
    err_nxt         = err_r;

    if (fire) begin
      if (cls.is_digit) begin
        acc_nxt = dec_sat;
      end else if (cls.is_letter) begin
        if (!cls.is_del) begin
          rd_sum_nxt = sat_add(rd_sum_r, acc_r);
          if (!cls.is_clip) begin
            al_sum_nxt = sat_add(al_sum_r, acc_r);
          end
        end
        if (!have_first_r) begin
          have_first_nxt = 1'b1;
          first_clip_nxt = cls.is_clip;
          first_len_nxt  = acc_r;
        end
        recent_clip_nxt = cls.is_clip;
        recent_len_nxt  = acc_r;
        acc_nxt         = '0;
      end else begin
        err_nxt = 1'b1;
      end
      // trailing digit flags an error
      if (eos && cls.is_digit) begin
        err_nxt = 1'b1;
      end
    end

    res.read_length     = clamp(rd_sum_nxt);
    res.aligned_length  = clamp(al_sum_nxt);
    res.front_clipped   = first_clip_nxt;
    res.back_clipped    = recent_clip_nxt;
    res.first_op_length = clamp(first_len_nxt);
    res.last_op_length  = clamp(recent_len_nxt);
    res.parse_error     = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && eos)) begin
      acc_r         <= '0;
      rd_sum_r      <= '0;
      al_sum_r      <= '0;
      have_first_r  <= 1'b0;
      first_clip_r  <= 1'b0;
      first_len_r   <= '0;
      recent_clip_r <= 1'b0;
      recent_len_r  <= '0;
      err_r         <= 1'b0;
    end else begin
      acc_r         <= acc_nxt;
      rd_sum_r      <= rd_sum_nxt;
      al_sum_r      <= al_sum_nxt;
      have_first_r  <= have_first_nxt;
      first_clip_r  <= first_clip_nxt;
      first_len_r   <= first_len_nxt;
      recent_clip_r <= recent_clip_nxt;
      recent_len_r  <= recent_len_nxt;
      err_r         <= err_nxt;
    end
  end

endmodule

FILE: design/cgp_out_reg.sv
module cgp_out_reg
  import cgp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  result_t               res,
  output logic                  free,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic    vld_r, vld_nxt;
  result_t res_r;

  assign free = !vld_r || out_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = OUT_DATA_W'(res_r);

endmodule

FILE: design/cigar_string_parser.sv
// Path: a final character goes through the input register, then the update
// logic into the result register, which drives the result beat.
// Throughput: one character per cycle; the only stall is a final character
// waiting while the result register still holds an untaken result.
// Reset: rst_n synchronous active low; clears the running lengths and flags and all valids.
module cigar_string_parser
  import cgp_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input characters
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] char_code
  input  logic                  in_tlast,   // end_of_string
  // one result beat per string
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] read_length, [63:32] aligned_length, [64] front_clipped,
  // [65] back_clipped, [97:66] first_op_length, [129:98] last_op_length,
  // [130] parse_error, [135:131] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // input register stage
  logic       s1_vld_r, s1_vld_nxt;
  logic [7:0] s1_char_r;
  logic       s1_eos_r;

  logic        out_free;
  logic        fire;
  char_class_t cls;
  result_t     res;

  // a non-final character never needs the result register
  assign fire      = s1_vld_r && (!s1_eos_r || out_free);
  assign in_tready = !s1_vld_r || fire;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_tvalid && in_tready) begin
      s1_vld_nxt = 1'b1;
    end else if (fire) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_char_r <= in_tdata;
      s1_eos_r  <= in_tlast;
    end
  end

  cgp_decode u_decode (
    .char_code (s1_char_r),
    .cls       (cls)
  );

  // running sums, first/last op tracking; clears itself after the final beat
  cgp_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .cls   (cls),
    .eos   (s1_eos_r),
    .res   (res)
  );

  cgp_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire && s1_eos_r),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Checks
  a_rst_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_result_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(fire && s1_eos_r))
    else $error("result without a final character");

  a_aligned_le_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[63:32] <= out_tdata[31:0]))
    else $error("aligned length exceeds read length");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> in_tready)
    else $error("empty input stage not ready");

endmodule

FILE: tb/sv/tb_cigar_string_parser.sv
module tb_cigar_string_parser
  import cgp_pkg::*;
();

  localparam logic [31:0] LEN_MAX  = '1;
  localparam int          IDLE_PCT = 26;       // rough share of idle cycles per side

  // ---------------------------------------------------------------------------
  // clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;    // [7:0] char_code
  logic                  in_tlast   = 1'b0;  // end_of_string
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;          // result_t in [130:0], zero above

  always #10 clk = ~clk;

  cigar_string_parser i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // ---------------------------------------------------------------------------
  // bookkeeping
  // ---------------------------------------------------------------------------
  logic    calm = 1'b0;           // set: neither side idles
  int      mismatches      = 0;
  int      chars_sent      = 0;
  int      strings_sent    = 0;
  int      results_checked = 0;
  int      malformed_strings = 0;
  int      saturated_strings = 0;
  result_t expected_summaries[$]; // one entry per string still owed by the DUT

  // ---------------------------------------------------------------------------
  // CIGAR tally, tracked per accepted character
  // ---------------------------------------------------------------------------
  logic [31:0] run_digits  = '0;  // length being typed in
  logic [31:0] read_sum    = '0;
  logic [31:0] aligned_sum = '0;
  logic [31:0] first_len   = '0;
  logic [31:0] recent_len  = '0;
  logic        have_first  = 1'b0;
  logic        first_clip  = 1'b0;
  logic        recent_clip = 1'b0;
  logic        bad_seen    = 1'b0;

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? LEN_MAX : s[31:0];
  endfunction

  function automatic logic [31:0] push_digit(input logic [31:0] acc, input logic [3:0] d);
    logic [35:0] v;
    v = {4'd0, acc} * 36'd10 + {32'd0, d};
    return (v > {4'd0, LEN_MAX}) ? LEN_MAX : v[31:0];
  endfunction

  task automatic tally_char(input logic [7:0] c, input logic eos);
    logic    is_digit;
    logic    clip;
    result_t r;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    clip     = (c == CH_S) || (c == CH_H);
    if (is_digit) begin
      run_digits = push_digit(run_digits, 4'(c - CH_ZERO));
    end else if ((c >= CH_A) && (c <= CH_Z)) begin
      // deletions don't consume read bases; clips don't align
      if (c != CH_D) begin
        read_sum = add_sat(read_sum, run_digits);
        if (!clip) aligned_sum = add_sat(aligned_sum, run_digits);
      end
      if (!have_first) begin
        have_first = 1'b1;
        first_clip = clip;
        first_len  = run_digits;
      end
      recent_clip = clip;
      recent_len  = run_digits;
      run_digits  = '0;
    end else begin
      // junk byte: flag it, keep any digits collected so far
      bad_seen = 1'b1;
    end
    if (eos) begin
      if (is_digit) bad_seen = 1'b1;  // dangling length, op dropped
      r.read_length     = read_sum;
      r.aligned_length  = aligned_sum;
      r.front_clipped   = first_clip;
      r.back_clipped    = recent_clip;
      r.first_op_length = first_len;
      r.last_op_length  = recent_len;
      r.parse_error     = bad_seen;
      expected_summaries.insert(expected_summaries.size(), r);
      strings_sent++;
      if (bad_seen) malformed_strings++;
      if ((read_sum == LEN_MAX) || (first_len == LEN_MAX) || (recent_len == LEN_MAX))
        saturated_strings++;
      run_digits  = '0;
      read_sum    = '0;
      aligned_sum = '0;
      first_len   = '0;
      recent_len  = '0;
      have_first  = 1'b0;
      first_clip  = 1'b0;
      recent_clip = 1'b0;
      bad_seen    = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure and the compare
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(result_t)-1:0];
      if (expected_summaries.size() == 0) begin
        mismatches++;
        $display("%0t: result beat expected none, got %h", $time, out_tdata);
      end else begin
        want = expected_summaries.pop_front();
        compare_field("read_length",     want.read_length,     got.read_length);
        compare_field("aligned_length",  want.aligned_length,  got.aligned_length);
        compare_field("front_clipped",   want.front_clipped,   got.front_clipped);
        compare_field("back_clipped",    want.back_clipped,    got.back_clipped);
        compare_field("first_op_length", want.first_op_length, got.first_op_length);
        compare_field("last_op_length",  want.last_op_length,  got.last_op_length);
        compare_field("parse_error",     want.parse_error,     got.parse_error);
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // character side
  // ---------------------------------------------------------------------------
  // Returns in the time step of the accepting edge with tvalid still high;
  // the caller either sends the next beat at once or drops tvalid right away.
  task automatic send_char(input logic [7:0] c, input logic eos);
    if (!calm && ($urandom_range(99) < IDLE_PCT)) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    tally_char(c, eos);
    chars_sent++;
  endtask

  task automatic send_string(input logic [7:0] text[$]);
    for (int i = 0; i < text.size(); i++)
      send_char(text[i], i == text.size() - 1);
  endtask

  task automatic send_text(input string s);
    logic [7:0] text[$];
    for (int i = 0; i < s.len(); i++) text.insert(text.size(), s[i]);
    send_string(text);
  endtask

  // bytes just outside the legal ranges, or anything at all
  function automatic logic [7:0] odd_char();
    case ($urandom_range(7))
      0:       return CH_ZERO - 8'd1;
      1:       return CH_NINE + 8'd1;
      2:       return CH_A - 8'd1;
      3:       return CH_Z + 8'd1;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly well-formed CIGARs with random lengths; a slice gets a junk byte,
  // a dangling number, or is pure junk.
  task automatic send_random_cigar();
    logic [7:0] text[$];
    int         n_ops;
    int         n_digits;
    int         flavor;
    string      ops;
    ops    = "MIDNSHPX";
    flavor = $urandom_range(99);
    n_ops  = $urandom_range(1, 5);
    for (int k = 0; k < n_ops; k++) begin
      // long numbers now and then, to hit saturation
      n_digits = ($urandom_range(39) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 3);
      repeat (n_digits) text.insert(text.size(), CH_ZERO + 8'($urandom_range(9)));
      if ($urandom_range(3) != 0) text.insert(text.size(), ops[$urandom_range(7)]);
      else                        text.insert(text.size(), CH_A + 8'($urandom_range(25)));
    end
    if (flavor < 8) begin
      text.insert($urandom_range(text.size()), odd_char());
    end else if (flavor < 14) begin
      repeat ($urandom_range(1, 3)) text.insert(text.size(), CH_ZERO + 8'($urandom_range(9)));
    end else if (flavor < 18) begin
      text.delete();
      repeat ($urandom_range(1, 4)) text.insert(text.size(), odd_char());
    end
    send_string(text);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    logic [7:0] text[$];
    send_text("1S2M3I4DNPX5H");   // every op, clips at both ends, zero lengths
    send_text("7");               // dangling number, no op at all
    text.insert(text.size(), CH_ZERO + 8'd2);
    text.insert(text.size(), 8'hFF);  // junk between the length and its op
    text.insert(text.size(), CH_H);
    send_string(text);
    send_text("9999999999M");     // length past 32 bits
  endtask

  task automatic test_random_traffic(input int n_chars);
    int stop_at;
    stop_at = chars_sent + n_chars;
    while (chars_sent < stop_at) send_random_cigar();
  endtask

  task automatic test_back_to_back(input int n_chars);
    calm = 1'b1;
    test_random_traffic(n_chars);
    calm = 1'b0;
  endtask

  // sender holds off until the DUT has delivered everything it owes
  task automatic test_drain_pauses();
    repeat (12) begin
      send_random_cigar();
      in_tvalid <= 1'b0;
      while (expected_summaries.size() != 0) @(posedge clk);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_traffic(300);
    test_back_to_back(150);
    test_drain_pauses();
    test_random_traffic(280);
    in_tvalid <= 1'b0;
    while (expected_summaries.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);  // catch any stray result beats
    $display("sent %0d CIGAR strings in %0d characters, %0d results compared",
             strings_sent, chars_sent, results_checked);
    $display("%0d strings malformed, %0d with a saturated length",
             malformed_strings, saturated_strings);
    if (mismatches == 0) begin
      $display("cigar_string_parser: match");
    end else begin
      $display("cigar_string_parser: mismatch");
    end
    $finish;
  end

  // hang guard, far beyond any legal run
  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", expected_summaries.size());
    $display("cigar_string_parser: mismatch");
    $finish;
  end

endmodule
